### src/iq_to_amplitude_phase_unit_macros.svh
// ----------------------------------------------------------------------------
// IQ amplitude/phase assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef IQ_TO_AMPLITUDE_PHASE_UNIT_MACROS_SVH
`define IQ_TO_AMPLITUDE_PHASE_UNIT_MACROS_SVH

// check an implication on every clock outside reset
`define IQAP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check an implication whose consequent must hold on the following clock
`define IQAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/iqap_pkg.sv
// ----------------------------------------------------------------------------
// IQ amplitude/phase package
// CORDIC angle table, register indexes and shared constants.
// ----------------------------------------------------------------------------
package iqap_pkg;

    localparam int CordicIters = 32;
    localparam int AccWidth    = 64;
    localparam int AmpWidth    = 18;
    localparam int PowWidth    = 43;
    localparam int ScaleWidth  = 24;
    localparam int ZeroWidth   = 16;
    localparam int CfgIdxWidth = 2;

    localparam logic [AmpWidth-1:0] AmpMax = '1;
    localparam logic [PowWidth-1:0] PowMax = '1;

    localparam logic [CfgIdxWidth-1:0] RegPowerScale  = 2'd0;
    localparam logic [CfgIdxWidth-1:0] RegZeroAngle   = 2'd1;
    localparam logic [CfgIdxWidth-1:0] RegPowerEnable = 2'd2;

    localparam logic [ScaleWidth-1:0] ScaleOne = 24'd65536;

    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] t;
        case (k)
            0:  t = 32'h20000000;  1:  t = 32'h12E4051E;  2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;  4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;  8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2F;  10: t = 32'h000A2F98;  11: t = 32'h000517CC;
            12: t = 32'h00028BE6;  13: t = 32'h000145F3;  14: t = 32'h0000A2FA;
            15: t = 32'h0000517D;  16: t = 32'h000028BE;  17: t = 32'h0000145F;
            18: t = 32'h00000A30;  19: t = 32'h00000518;  20: t = 32'h0000028C;
            21: t = 32'h00000146;  22: t = 32'h000000A3;  23: t = 32'h00000051;
            24: t = 32'h00000029;  25: t = 32'h00000014;  26: t = 32'h0000000A;
            27: t = 32'h00000005;  28: t = 32'h00000003;  29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

### src/iqap_cordic_stage.sv
// ----------------------------------------------------------------------------
// IQ amplitude/phase CORDIC stage
// One registered vectoring micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module iqap_cordic_stage
    import iqap_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [AccWidth-1:0]  i_x,
    input  logic [AccWidth-1:0]  i_y,
    input  logic [31:0]          i_z,
    output logic [AccWidth-1:0]  o_x,
    output logic [AccWidth-1:0]  o_y,
    output logic [31:0]          o_z
);

    logic signed [AccWidth-1:0] w_x, w_y, w_dx, w_dy;
    logic [AccWidth-1:0] n_x, n_y, r_x, r_y;
    logic [31:0] n_z, r_z;

    assign w_x  = $signed(i_x);
    assign w_y  = $signed(i_y);
    assign w_dx = w_y >>> STAGE;
    assign w_dy = w_x >>> STAGE;

    always_comb begin
        if (w_y > 0) begin
            n_x = AccWidth'(w_x + w_dx);
            n_y = AccWidth'(w_y - w_dy);
            n_z = i_z + atan_turn(STAGE);
        end else begin
            n_x = AccWidth'(w_x - w_dx);
            n_y = AccWidth'(w_y + w_dy);
            n_z = i_z - atan_turn(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

### src/iq_to_amplitude_phase_unit.sv
// ----------------------------------------------------------------------------
// IQ to amplitude/phase unit
// Converts signed I/Q samples to amplitude, phase and scaled power.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction: i_valid with i_in_phase, i_quadrature, i_in_last;
//   accepted when i_valid is high and o_stall is low.
//   Output transaction: o_valid with o_amplitude, o_phase, o_power,
//   o_out_last; taken when o_valid is high and i_stall is low.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index, i_cfg_data;
//   index 0 power scale, 1 zero angle, 2 power enable. Write only when idle.
//   Throughput: one transaction per cycle unless the output is held by a stall.
//   Latency: 36 register stages from an accepted input to o_valid: input and
//   square-sum, 32 CORDIC stages, rounding, power multiply and output. The
//   square root runs alongside as 18 bit-pair steps in the first stages.
//   All stages advance together; when the receiver stalls with a full output
//   register the whole pipe holds and o_stall rises, so nothing is lost.
//   Reset clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module iq_to_amplitude_phase_unit
    import iqap_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 18,
    parameter int ANGLE_WIDTH  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_phase,
    input  logic signed [SAMPLE_WIDTH-1:0] i_quadrature,
    input  logic                           i_in_last,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [AmpWidth-1:0]            o_amplitude,
    output logic signed [ANGLE_WIDTH-1:0]  o_phase,
    output logic [PowWidth-1:0]            o_power,
    output logic                           o_out_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CfgIdxWidth-1:0]         i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    localparam int N     = CordicIters;
    localparam int Depth = N + 4;
    localparam int SqW   = 2 * SAMPLE_WIDTH;
    localparam int RtW   = SAMPLE_WIDTH + 1;
    localparam int Shl   = 61 - SAMPLE_WIDTH;
    localparam int Sh    = 32 - ANGLE_WIDTH;
    localparam int SqSteps = (SqW + 1) / 2;

    logic [ScaleWidth-1:0] r_scale;
    logic signed [ZeroWidth-1:0] r_zero;
    logic r_pen;

    logic w_adv;
    logic [Depth-1:0] r_v;

    assign w_adv = !(r_v[Depth-1] && i_stall);
    assign o_stall = !w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= ScaleOne;
            r_zero  <= '0;
            r_pen   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegPowerScale:  r_scale <= i_cfg_data[ScaleWidth-1:0];
                RegZeroAngle:   r_zero  <= i_cfg_data[ZeroWidth-1:0];
                RegPowerEnable: r_pen   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[Depth-2:0], i_valid};
        end
    end

    // stage 0: register input, pre-rotate, squares
    logic [AccWidth-1:0] r_x0, r_y0;
    logic [31:0] r_z0;
    logic r_zero_vec0;
    logic [SqW:0] r_s0;
    logic signed [AccWidth-1:0] w_xi, w_yi;
    logic [SAMPLE_WIDTH:0] w_ai, w_aq;

    assign w_xi = AccWidth'($signed(i_in_phase)) <<< Shl;
    assign w_yi = AccWidth'($signed(i_quadrature)) <<< Shl;
    assign w_ai = i_in_phase[SAMPLE_WIDTH-1]
                ? (SAMPLE_WIDTH+1)'(-$signed({i_in_phase[SAMPLE_WIDTH-1], i_in_phase}))
                : {1'b0, i_in_phase};
    assign w_aq = i_quadrature[SAMPLE_WIDTH-1]
                ? (SAMPLE_WIDTH+1)'(-$signed({i_quadrature[SAMPLE_WIDTH-1], i_quadrature}))
                : {1'b0, i_quadrature};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_xi < 0) begin
                r_x0 <= AccWidth'(-w_xi);
                r_y0 <= AccWidth'(-w_yi);
                r_z0 <= 32'h80000000;
            end else begin
                r_x0 <= w_xi;
                r_y0 <= w_yi;
                r_z0 <= '0;
            end
            r_zero_vec0 <= (i_in_phase == '0) && (i_quadrature == '0);
            r_s0 <= (SqW+1)'(w_ai * w_ai) + (SqW+1)'(w_aq * w_aq);
        end
    end

    // CORDIC chain
    logic [AccWidth-1:0] w_x [N+1];
    logic [AccWidth-1:0] w_y [N+1];
    logic [31:0]         w_z [N+1];
    assign w_x[0] = r_x0;
    assign w_y[0] = r_y0;
    assign w_z[0] = r_z0;

    for (genvar k = 0; k < N; k++) begin : g_cordic
        iqap_cordic_stage #(.STAGE(k)) u_stage (
            .i_clk(i_clk), .i_en(w_adv),
            .i_x(w_x[k]), .i_y(w_y[k]), .i_z(w_z[k]),
            .o_x(w_x[k+1]), .o_y(w_y[k+1]), .o_z(w_z[k+1])
        );
    end

    // side pipeline: sum of squares, sqrt, flags, over N stages
    logic [SqW:0]  r_s   [N+1];
    logic [SqW:0]  r_rem [N+1];
    logic [RtW:0]  r_rt  [N+1];
    logic          r_zv  [N+1];
    logic          r_last[N+1];
    logic          r_last_in;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_last_in <= i_in_last;
        end
    end

    assign r_s[0]    = r_s0;
    assign r_rem[0]  = r_s0;
    assign r_rt[0]   = '0;
    assign r_zv[0]   = r_zero_vec0;
    assign r_last[0] = r_last_in;

    for (genvar k = 0; k < N; k++) begin : g_side
        logic [SqW:0] n_rem;
        logic [RtW:0] n_rt;
        logic [SqW:0] r_s_q, r_rem_q;
        logic [RtW:0] r_rt_q;
        logic r_zv_q, r_last_q;
        always_comb begin
            n_rem = r_rem[k];
            n_rt  = r_rt[k];
            if (k < SqSteps) begin
                // one bit pair per stage, MSB first
                logic [SqW+2:0] trial;
                logic [SqW+2:0] part;
                trial = (SqW+3)'({n_rt, 2'b01}) << (2 * (SqSteps - 1 - k));
                part  = (SqW+3)'(n_rem);
                if (part >= trial) begin
                    n_rem = (SqW+1)'(part - trial);
                    n_rt  = (RtW+1)'({n_rt, 1'b1});
                end else begin
                    n_rt  = (RtW+1)'({n_rt, 1'b0});
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_s_q    <= r_s[k];
                r_rem_q  <= n_rem;
                r_rt_q   <= n_rt;
                r_zv_q   <= r_zv[k];
                r_last_q <= r_last[k];
            end
        end
        assign r_s[k+1]    = r_s_q;
        assign r_rem[k+1]  = r_rem_q;
        assign r_rt[k+1]   = r_rt_q;
        assign r_zv[k+1]   = r_zv_q;
        assign r_last[k+1] = r_last_q;
    end

    // stage N+1: round amp and phase, register square sum and power scale
    logic [RtW:0] w_amp_r;
    logic [31:0]  w_ph_r;
    logic [AmpWidth-1:0] r_amp1, r_amp2;
    logic [ANGLE_WIDTH-1:0] r_ph1, r_ph2;
    logic [SqW:0] r_s1;
    logic [ScaleWidth-1:0] r_sc1;
    logic r_pen1, r_last1, r_last2, r_pen2;
    logic [ScaleWidth+SqW:0] r_prod;

    assign w_amp_r = (r_rem[N] > (SqW+1)'(r_rt[N])) ? r_rt[N] + 1'b1 : r_rt[N];
    assign w_ph_r  = w_z[N] + (32'd1 << (Sh - 1));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_amp1 <= (w_amp_r > (RtW+1)'(AmpMax)) ? AmpMax : AmpWidth'(w_amp_r);
            r_ph1  <= (r_zv[N] ? '0 : w_ph_r[31 -: ANGLE_WIDTH])
                    + ANGLE_WIDTH'($signed(r_zero));
            r_s1   <= r_s[N];
            r_sc1  <= (r_scale == '0) ? ScaleOne : r_scale;
            r_pen1 <= r_pen;
            r_last1 <= r_last[N];
        end
    end

    // stage N+2: multiply (24 x 37)
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod  <= (ScaleWidth+SqW+1)'(r_s1 * r_sc1) + (ScaleWidth+SqW+1)'(32768);
            r_amp2  <= r_amp1;
            r_ph2   <= r_ph1;
            r_pen2  <= r_pen1;
            r_last2 <= r_last1;
        end
    end

    // output register
    logic [AmpWidth-1:0] r_amp_o;
    logic [ANGLE_WIDTH-1:0] r_ph_o;
    logic [PowWidth-1:0] r_pw_o;
    logic r_last_o;
    logic [ScaleWidth+SqW-16:0] w_pw;

    assign w_pw = r_prod[ScaleWidth+SqW:16];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_amp_o  <= r_amp2;
            r_ph_o   <= r_ph2;
            r_last_o <= r_last2;
            if (!r_pen2)
                r_pw_o <= '0;
            else if ((ScaleWidth+SqW-15) > PowWidth && (w_pw >> PowWidth) != '0)
                r_pw_o <= PowMax;
            else
                r_pw_o <= PowWidth'(w_pw);
        end
    end

    assign o_valid     = r_v[Depth-1];
    assign o_amplitude = r_amp_o;
    assign o_phase     = r_ph_o;
    assign o_power     = r_pw_o;
    assign o_out_last  = r_last_o;

endmodule

### src/iqap_checker.sv
// ----------------------------------------------------------------------------
// IQ amplitude/phase port checker
// Port-level checks bound to the top level.
// ----------------------------------------------------------------------------
`include "iq_to_amplitude_phase_unit_macros.svh"

module iqap_checker
    import iqap_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [AmpWidth-1:0] o_amplitude,
    input logic [PowWidth-1:0] o_power,
    input logic                o_cfg_ready
);

    `IQAP_ASSERT_IMP(a_stall_only_when_out_held, i_clk, i_rst_n,
        o_stall, o_valid && i_stall, "input stalled without a held output")
    `IQAP_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n,
        o_valid && i_stall, o_valid && $stable(o_amplitude) && $stable(o_power),
        "held output changed")
    `IQAP_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n,
        1'b1, o_cfg_ready, "config port not ready")

endmodule

bind iq_to_amplitude_phase_unit iqap_checker u_iqap_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_amplitude(o_amplitude),
    .o_power(o_power), .o_cfg_ready(o_cfg_ready)
);

### tb/sv/iq_to_amplitude_phase_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IQ to amplitude/phase checker
// Watches the sample, result and register channels, predicts amplitude,
// phase, power and last flag for every accepted sample and compares them in
// order. Amplitude and phase may differ from the prediction by one LSB.
// ----------------------------------------------------------------------------
module iq_to_amplitude_phase_checker
    import iqap_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_stall_in,
    input  logic signed [17:0]     i_in_phase,
    input  logic signed [17:0]     i_quadrature,
    input  logic                   i_in_last,
    input  logic                   i_out_valid,
    input  logic                   i_stall_out,
    input  logic [AmpWidth-1:0]    i_amplitude,
    input  logic signed [15:0]     i_phase,
    input  logic [PowWidth-1:0]    i_power,
    input  logic                   i_out_last,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CfgIdxWidth-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_results
);

    typedef struct packed {
        logic [AmpWidth-1:0] amplitude;
        logic [15:0]         phase;
        logic [PowWidth-1:0] power;
        logic                last;
    } polar_t;

    polar_t                expected_polar[$];
    logic [ScaleWidth-1:0] scale_reg;
    logic signed [15:0]    zero_reg;
    logic                  power_on_reg;

    function automatic logic [63:0] round_sqrt(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'd1 << 62;
        x = s;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (s - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic logic [31:0] vector_turns(input longint i, input longint q);
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [31:0] z;
        x = i <<< 43;
        y = q <<< 43;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int k = 0; k < CordicIters; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + atan_turn(k);
            end else begin
                x = x - dx; y = y + dy; z = z - atan_turn(k);
            end
        end
        return z;
    endfunction

    function automatic polar_t predict_polar(input logic signed [17:0] i_s,
                                             input logic signed [17:0] q_s,
                                             input logic last);
        polar_t      p;
        longint      iv;
        longint      qv;
        logic [63:0] s;
        logic [63:0] amp;
        logic [63:0] sc;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] r;
        logic [15:0] ph;
        iv = longint'(i_s);
        qv = longint'(q_s);
        s = iv * iv + qv * qv;
        amp = round_sqrt(s);
        p.amplitude = (amp > AmpMax) ? AmpMax : amp[AmpWidth-1:0];
        if (iv == 0 && qv == 0) ph = '0;
        else ph = 16'((vector_turns(iv, qv) + 32'h8000) >> 16);
        p.phase = ph + zero_reg;
        p.power = '0;
        if (power_on_reg) begin
            sc = (scale_reg == 0) ? 64'd65536 : 64'(scale_reg);
            hi = sc * (s >> 32);
            lo = sc * (s & 64'hFFFFFFFF) + 64'd32768;
            r = (hi << 16) + (lo >> 16);
            if (hi >= (64'd1 << 27) || r > PowMax) p.power = PowMax;
            else p.power = r[PowWidth-1:0];
        end
        p.last = last;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        o_errors = o_errors + 1;
    endtask

    function automatic bit near(input longint a, input longint b, input longint m);
        longint d;
        d = (a - b) % m;
        if (d < 0) d = d + m;
        return d <= 1 || d == m - 1;
    endfunction

    initial begin
        o_errors = 0;
        o_results = 0;
    end

    assign o_pending = expected_polar.size();

    always @(posedge i_clk) begin
        polar_t want;
        if (!i_rst_n) begin
            scale_reg    <= ScaleOne;
            zero_reg     <= '0;
            power_on_reg <= 1'b1;
            expected_polar.delete();
        end else begin
            if (i_out_valid && !i_stall_out) begin
                o_results = o_results + 1;
                if (expected_polar.size() == 0) begin
                    report_mismatch("unexpected transaction", 64'sd0, 64'sd0);
                end else begin
                    want = expected_polar.pop_front();
                    if (!near(longint'(i_amplitude), longint'(want.amplitude), 64'sd1 << 40))
                        report_mismatch("amplitude", longint'(i_amplitude),
                                        longint'(want.amplitude));
                    if (!near(longint'(i_phase), longint'(want.phase), 64'sd65536))
                        report_mismatch("phase", longint'(i_phase),
                                        longint'($signed(want.phase)));
                    if (i_power !== want.power)
                        report_mismatch("power", longint'(i_power), longint'(want.power));
                    if (i_out_last !== want.last)
                        report_mismatch("last", longint'(i_out_last), longint'(want.last));
                end
            end
            if (i_valid && !i_stall_in)
                expected_polar.push_back(predict_polar(i_in_phase, i_quadrature, i_in_last));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    RegPowerScale:  scale_reg <= i_cfg_data[ScaleWidth-1:0];
                    RegZeroAngle:   zero_reg <= i_cfg_data[15:0];
                    RegPowerEnable: power_on_reg <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/sv/iq_to_amplitude_phase_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IQ to amplitude/phase unit testbench
// Drives directed and random I/Q samples in bursts through several register
// settings while the receiver stalls at random; the checker compares results.
// ----------------------------------------------------------------------------
module iq_to_amplitude_phase_unit_test;
    import iqap_pkg::*;

    localparam int Latency = 36;
    localparam int WatchdogLimit = 5000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [17:0]     in_i;
    logic signed [17:0]     in_q;
    logic                   in_last;
    logic                   out_valid;
    logic                   out_stall;
    logic [AmpWidth-1:0]    out_amplitude;
    logic signed [15:0]     out_phase;
    logic [PowWidth-1:0]    out_power;
    logic                   out_last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [31:0]            cfg_data;
    int                     errors;
    int                     pending;
    int                     results;
    int                     idle_cycles;
    int                     sample_count;

    iq_to_amplitude_phase_unit dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_in_phase(in_i), .i_quadrature(in_q), .i_in_last(in_last),
        .o_valid(out_valid), .i_stall(out_stall), .o_amplitude(out_amplitude),
        .o_phase(out_phase), .o_power(out_power), .o_out_last(out_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    iq_to_amplitude_phase_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_in_phase(in_i), .i_quadrature(in_q), .i_in_last(in_last),
        .i_out_valid(out_valid), .i_stall_out(out_stall), .i_amplitude(out_amplitude),
        .i_phase(out_phase), .i_power(out_power), .i_out_last(out_last),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .o_errors(errors), .o_pending(pending),
        .o_results(results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern: calm stretches, then random stall phases
    always @(posedge clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!rst_n) out_stall <= 1'b0;
        else if ((sample_count / 80) % 3 == 1) out_stall <= 1'b0;
        else out_stall <= (r < 30);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("watchdog expired");
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [17:0] i_s, input logic signed [17:0] q_s,
                               input logic last);
        in_valid <= 1'b1;
        in_i     <= i_s;
        in_q     <= q_s;
        in_last  <= last;
        do @(posedge clk); while (in_stall);
        sample_count = sample_count + 1;
    endtask

    task automatic drain_pipe;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
    endtask

    function automatic logic signed [17:0] random_field;
        int m;
        m = $urandom_range(0, 9);
        if (m == 0) return $urandom_range(0, 1) ? 18'sh1FFFF : 18'sh20000;
        if (m < 3) return $signed(18'($urandom_range(0, 15)) - 18'd8);
        return $signed(18'($urandom));
    endfunction

    task automatic random_burst(input int count);
        int left;
        left = count;
        while (left > 0) begin
            for (int n = $urandom_range(1, 16); n > 0 && left > 0; n--) begin
                send_sample(random_field(), random_field(), 1'($urandom_range(0, 1)));
                left--;
            end
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_i = '0;
        in_q = '0;
        in_last = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = RegPowerScale;
        cfg_data = '0;
        sample_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(18'sd0, 18'sd0, 1'b0);
        send_sample(18'sh1FFFF, 18'sd0, 1'b1);
        send_sample(18'sh20000, 18'sd0, 1'b0);
        send_sample(18'sd0, 18'sh1FFFF, 1'b0);
        send_sample(18'sd0, 18'sh20000, 1'b1);
        send_sample(18'sh20000, 18'sh20000, 1'b0);
        send_sample(18'sh1FFFF, 18'sh1FFFF, 1'b0);
        send_sample(18'sh20000, 18'sh1FFFF, 1'b0);
        send_sample(-18'sd1, 18'sd0, 1'b0);
        send_sample(-18'sd1, -18'sd1, 1'b1);
        send_sample(18'sd1, -18'sd1, 1'b0);
        send_sample(18'sd3, 18'sd4, 1'b0);
        drain_pipe();

        write_reg(RegPowerEnable, 32'd0);
        write_reg(RegZeroAngle, 32'h00007FFF);
        send_sample(18'sd0, 18'sd0, 1'b1);
        send_sample(18'sh1FFFF, 18'sh1FFFF, 1'b0);
        send_sample(-18'sd100, 18'sd5, 1'b0);
        drain_pipe();

        write_reg(RegPowerEnable, 32'd1);
        write_reg(RegPowerScale, 32'h00FFFFFF);
        write_reg(RegZeroAngle, 32'hFFFF8000);
        send_sample(18'sh20000, 18'sh20000, 1'b0);
        send_sample(18'sd0, 18'sd0, 1'b0);
        send_sample(18'sd1000, -18'sd3000, 1'b1);
        drain_pipe();

        write_reg(RegPowerScale, 32'd0);
        random_burst(200);
        drain_pipe();

        write_reg(RegPowerScale, 32'd1);
        write_reg(RegZeroAngle, 32'($urandom_range(0, 65535)));
        random_burst(200);
        drain_pipe();

        write_reg(RegPowerScale, 32'($urandom_range(0, 24'hFFFFFF)));
        write_reg(RegPowerEnable, 32'd0);
        random_burst(100);
        drain_pipe();

        write_reg(RegPowerEnable, 32'd1);
        write_reg(RegPowerScale, 32'h00FFFFFF);
        write_reg(RegZeroAngle, 32'd0);
        random_burst(130);
        drain_pipe();

        $display("%0d samples sent, %0d results checked over seven register settings",
                 sample_count, results);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### iq_to_amplitude_phase_unit.f
+incdir+src
src/iqap_pkg.sv
src/iqap_cordic_stage.sv
src/iq_to_amplitude_phase_unit.sv
src/iqap_checker.sv
tb/sv/iq_to_amplitude_phase_checker.sv
tb/sv/iq_to_amplitude_phase_unit_test.sv
